[hw/rtl/wfpa_pkg.sv]
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared types, constants and controller/datapath command codes for the
// worst-fit partition allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  localparam int MaxParts = 64;
  localparam int IdxW     = $clog2(MaxParts);
  localparam int CntW     = $clog2(MaxParts + 1);
  localparam int AddrW    = 48;
  localparam int TagW     = 31;
  localparam int SizeW    = 32;
  localparam int PageW    = 32;
  localparam int DivCntW  = $clog2(SizeW + 1);

  localparam logic [PageW-1:0] PageReset = PageW'(4096);

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic STAT_DONE    = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  // One partition table entry
  typedef struct packed {
    logic             free;
    logic [TagW-1:0]  owner;
    logic [AddrW-1:0] len;
    logic [AddrW-1:0] start;
    logic [IdxW-1:0]  link;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_AS_EV,
    S_AL_DEC,
    S_DIV,
    S_PAGES,
    S_MUL,
    S_LEN,
    S_CHECK,
    S_GRAB_C,
    S_WR_TAIL,
    S_GRAB_R,
    S_WR_REM,
    S_WR_CH,
    S_FR_RD,
    S_FR_EV,
    S_CO_START,
    S_CO_LOAD,
    S_CO_CHK,
    S_CO_EV,
    S_ST_START,
    S_ST_EV,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_START,
    ACT_AS_EVAL,
    ACT_AL_DECIDE,
    ACT_DIV_STEP,
    ACT_PAGES,
    ACT_MUL,
    ACT_LEN,
    ACT_CHECK,
    ACT_GRAB_C,
    ACT_WR_TAIL,
    ACT_GRAB_R,
    ACT_WR_REM,
    ACT_WR_CH,
    ACT_FR_RD,
    ACT_FR_EVAL,
    ACT_CO_START,
    ACT_CO_LOAD,
    ACT_CO_RDNEXT,
    ACT_CO_EVAL,
    ACT_ST_START,
    ACT_ST_EVAL,
    ACT_LOAD_OUT
  } act_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic used_zero;
    logic scan_last;
    logic need_div;
    logic div_last;
    logic full;
    logic make_new;
    logic split;
    logic was_empty;
    logic fr_last;
    logic at_tail;
    logic out_busy;
  } stat_t;

endpackage

[hw/rtl/wfpa_if.sv]
// ----------------------------------------------------------------------------
// wfpa channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wfpa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [wfpa_pkg::TagW-1:0] tag;
  logic [wfpa_pkg::SizeW-1:0] size;
  modport source (output valid, op, tag, size, input ready);
  modport sink   (input valid, op, tag, size, output ready);
endinterface

interface wfpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [wfpa_pkg::AddrW-1:0] alloc_addr;
  logic [wfpa_pkg::AddrW-1:0] pages_total;
  logic [wfpa_pkg::AddrW-1:0] largest_free_size;
  logic [wfpa_pkg::AddrW-1:0] largest_free_addr;
  modport source (output valid, status, alloc_addr, pages_total, largest_free_size,
                  largest_free_addr, input ready);
  modport sink   (input valid, status, alloc_addr, pages_total, largest_free_size,
                  largest_free_addr, output ready);
endinterface

interface wfpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wfpa_pkg::PageW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/wfpa_ctrl.sv]
// ----------------------------------------------------------------------------
// wfpa_ctrl
// Sequencer for the allocator: walks scan, divide, split, release, merge and
// statistics phases and issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module wfpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  wfpa_pkg::stat_t stat,
  output wfpa_pkg::cmd_t  cmd
);

  wfpa_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wfpa_pkg::S_IDLE: begin
        if (req_valid) begin
          if (stat.req_free) begin
            state_next = wfpa_pkg::S_FR_RD;
          end else if (stat.used_zero) begin
            state_next = wfpa_pkg::S_AL_DEC;
          end else begin
            state_next = wfpa_pkg::S_AS_EV;
          end
        end
      end
      wfpa_pkg::S_AS_EV: begin
        if (stat.scan_last) state_next = wfpa_pkg::S_AL_DEC;
      end
      wfpa_pkg::S_AL_DEC: begin
        state_next = stat.need_div ? wfpa_pkg::S_DIV : wfpa_pkg::S_CHECK;
      end
      wfpa_pkg::S_DIV: begin
        if (stat.div_last) state_next = wfpa_pkg::S_PAGES;
      end
      wfpa_pkg::S_PAGES: state_next = wfpa_pkg::S_MUL;
      wfpa_pkg::S_MUL:   state_next = wfpa_pkg::S_LEN;
      wfpa_pkg::S_LEN:   state_next = wfpa_pkg::S_CHECK;
      wfpa_pkg::S_CHECK: begin
        if (stat.full) begin
          state_next = wfpa_pkg::S_ST_START;
        end else if (stat.make_new) begin
          state_next = wfpa_pkg::S_GRAB_C;
        end else begin
          state_next = stat.split ? wfpa_pkg::S_GRAB_R : wfpa_pkg::S_WR_CH;
        end
      end
      wfpa_pkg::S_GRAB_C: begin
        if (!stat.was_empty) begin
          state_next = wfpa_pkg::S_WR_TAIL;
        end else begin
          state_next = stat.split ? wfpa_pkg::S_GRAB_R : wfpa_pkg::S_WR_CH;
        end
      end
      wfpa_pkg::S_WR_TAIL: begin
        state_next = stat.split ? wfpa_pkg::S_GRAB_R : wfpa_pkg::S_WR_CH;
      end
      wfpa_pkg::S_GRAB_R:   state_next = wfpa_pkg::S_WR_REM;
      wfpa_pkg::S_WR_REM:   state_next = wfpa_pkg::S_WR_CH;
      wfpa_pkg::S_WR_CH:    state_next = wfpa_pkg::S_ST_START;
      wfpa_pkg::S_FR_RD:    state_next = wfpa_pkg::S_FR_EV;
      wfpa_pkg::S_FR_EV: begin
        state_next = stat.fr_last ? wfpa_pkg::S_CO_START : wfpa_pkg::S_FR_RD;
      end
      wfpa_pkg::S_CO_START: begin
        state_next = stat.used_zero ? wfpa_pkg::S_ST_START : wfpa_pkg::S_CO_LOAD;
      end
      wfpa_pkg::S_CO_LOAD: state_next = wfpa_pkg::S_CO_CHK;
      wfpa_pkg::S_CO_CHK: begin
        state_next = stat.at_tail ? wfpa_pkg::S_ST_START : wfpa_pkg::S_CO_EV;
      end
      wfpa_pkg::S_CO_EV: state_next = wfpa_pkg::S_CO_CHK;
      wfpa_pkg::S_ST_START: begin
        state_next = stat.used_zero ? wfpa_pkg::S_DONE : wfpa_pkg::S_ST_EV;
      end
      wfpa_pkg::S_ST_EV: begin
        if (stat.scan_last) state_next = wfpa_pkg::S_DONE;
      end
      wfpa_pkg::S_DONE: begin
        if (!stat.out_busy) state_next = wfpa_pkg::S_IDLE;
      end
      default: state_next = wfpa_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd.act   = wfpa_pkg::ACT_NONE;
    req_ready = 1'b0;
    unique case (state)
      wfpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd.act = wfpa_pkg::ACT_START;
      end
      wfpa_pkg::S_AS_EV:    cmd.act = wfpa_pkg::ACT_AS_EVAL;
      wfpa_pkg::S_AL_DEC:   cmd.act = wfpa_pkg::ACT_AL_DECIDE;
      wfpa_pkg::S_DIV:      cmd.act = wfpa_pkg::ACT_DIV_STEP;
      wfpa_pkg::S_PAGES:    cmd.act = wfpa_pkg::ACT_PAGES;
      wfpa_pkg::S_MUL:      cmd.act = wfpa_pkg::ACT_MUL;
      wfpa_pkg::S_LEN:      cmd.act = wfpa_pkg::ACT_LEN;
      wfpa_pkg::S_CHECK:    cmd.act = wfpa_pkg::ACT_CHECK;
      wfpa_pkg::S_GRAB_C:   cmd.act = wfpa_pkg::ACT_GRAB_C;
      wfpa_pkg::S_WR_TAIL:  cmd.act = wfpa_pkg::ACT_WR_TAIL;
      wfpa_pkg::S_GRAB_R:   cmd.act = wfpa_pkg::ACT_GRAB_R;
      wfpa_pkg::S_WR_REM:   cmd.act = wfpa_pkg::ACT_WR_REM;
      wfpa_pkg::S_WR_CH:    cmd.act = wfpa_pkg::ACT_WR_CH;
      wfpa_pkg::S_FR_RD:    cmd.act = wfpa_pkg::ACT_FR_RD;
      wfpa_pkg::S_FR_EV:    cmd.act = wfpa_pkg::ACT_FR_EVAL;
      wfpa_pkg::S_CO_START: cmd.act = wfpa_pkg::ACT_CO_START;
      wfpa_pkg::S_CO_LOAD:  cmd.act = wfpa_pkg::ACT_CO_LOAD;
      wfpa_pkg::S_CO_CHK: begin
        if (!stat.at_tail) cmd.act = wfpa_pkg::ACT_CO_RDNEXT;
      end
      wfpa_pkg::S_CO_EV:    cmd.act = wfpa_pkg::ACT_CO_EVAL;
      wfpa_pkg::S_ST_START: cmd.act = wfpa_pkg::ACT_ST_START;
      wfpa_pkg::S_ST_EV:    cmd.act = wfpa_pkg::ACT_ST_EVAL;
      wfpa_pkg::S_DONE: begin
        if (!stat.out_busy) cmd.act = wfpa_pkg::ACT_LOAD_OUT;
      end
      default: cmd.act = wfpa_pkg::ACT_NONE;
    endcase
  end

endmodule

[hw/rtl/wfpa_dp.sv]
// ----------------------------------------------------------------------------
// wfpa_dp
// Datapath: partition table memory, list pointers, page divider and
// multiplier, statistics registers and the result register.
// ----------------------------------------------------------------------------
module wfpa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  wfpa_pkg::cmd_t             cmd,
  output wfpa_pkg::stat_t            stat,
  input  logic                       req_op,
  input  logic [wfpa_pkg::TagW-1:0]  req_tag,
  input  logic [wfpa_pkg::SizeW-1:0] req_size,
  input  logic                       cfg_we,
  input  logic [wfpa_pkg::PageW-1:0] cfg_data,
  input  logic                       rsp_ready,
  output logic                       rsp_valid,
  output logic                       rsp_status,
  output logic [wfpa_pkg::AddrW-1:0] rsp_alloc_addr,
  output logic [wfpa_pkg::AddrW-1:0] rsp_pages_total,
  output logic [wfpa_pkg::AddrW-1:0] rsp_largest_free_size,
  output logic [wfpa_pkg::AddrW-1:0] rsp_largest_free_addr
);

  localparam int IdxW  = wfpa_pkg::IdxW;
  localparam int CntW  = wfpa_pkg::CntW;
  localparam int AddrW = wfpa_pkg::AddrW;
  localparam int SizeW = wfpa_pkg::SizeW;
  localparam int PageW = wfpa_pkg::PageW;

  // Table memory and control state
  wfpa_pkg::entry_t mem [wfpa_pkg::MaxParts];
  wfpa_pkg::entry_t rd_data;
  logic [wfpa_pkg::MaxParts-1:0] valid;
  logic [CntW-1:0]  used;
  logic [IdxW-1:0]  head, tail;
  logic [AddrW-1:0] page_count;
  logic [PageW-1:0] page_bytes;

  // Per-request working registers
  logic [wfpa_pkg::TagW-1:0] tag;
  logic [SizeW-1:0]  size;
  logic [CntW-1:0]   cnt;
  logic [IdxW-1:0]   cur_idx;
  wfpa_pkg::entry_t  cur_e;
  logic              best_found;
  logic [IdxW-1:0]   best_idx;
  wfpa_pkg::entry_t  best_e;
  wfpa_pkg::entry_t  tail_e;
  logic [IdxW-1:0]   old_tail;
  logic              make_new, grow, was_empty;
  logic [AddrW-1:0]  chosen_len, ch_start;
  logic [IdxW-1:0]   chosen_idx, ch_link, slot_r;
  logic [SizeW-1:0]  quo;
  logic [PageW-1:0]  rem;
  logic [wfpa_pkg::DivCntW-1:0] dcnt;
  logic [SizeW-1:0]  new_pages;
  logic [AddrW-1:0]  prod;
  logic              dropped;
  logic [AddrW-1:0]  alloc_addr, bsize, baddr;

  // Combinational helpers
  logic [PageW-1:0]  unit;
  logic [AddrW-1:0]  size_w;
  logic              use_best, split, full;
  logic [CntW-1:0]   needed;
  logic [PageW:0]    r_sh;
  logic [63:0]       mul_full;
  logic [IdxW-1:0]   first_free;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  wfpa_pkg::entry_t  wr_data;
  wfpa_pkg::entry_t  merged;
  logic              rsp_load;

  assign unit     = (page_bytes == '0) ? PageW'(1) : page_bytes;
  assign size_w   = AddrW'(size);
  assign use_best = best_found && (best_e.len >= size_w);
  assign split    = chosen_len > size_w;
  assign needed   = CntW'(make_new) + CntW'(split);
  assign full     = ({1'b0, used} + {1'b0, needed}) > (CntW + 1)'(wfpa_pkg::MaxParts);
  assign r_sh     = {rem, quo[SizeW-1]};
  assign mul_full = 64'(new_pages) * 64'(unit);
  assign rsp_load = (cmd.act == wfpa_pkg::ACT_LOAD_OUT);

  // Lowest unused table slot
  always_comb begin
    first_free = '0;
    for (int i = wfpa_pkg::MaxParts - 1; i >= 0; i--) begin
      if (!valid[i]) first_free = IdxW'(i);
    end
  end

  // Merged entry for the coalesce step
  always_comb begin
    merged      = cur_e;
    merged.len  = cur_e.len + rd_data.len;
    merged.link = rd_data.link;
  end

  // Status to the controller
  always_comb begin
    stat.req_free  = (req_op == wfpa_pkg::OP_FREE);
    stat.used_zero = (used == '0);
    stat.scan_last = (cnt + CntW'(1)) == used;
    stat.need_div  = (used == '0) || !use_best;
    stat.div_last  = (dcnt == wfpa_pkg::DivCntW'(1));
    stat.full      = full;
    stat.make_new  = make_new;
    stat.split     = split;
    stat.was_empty = was_empty;
    stat.fr_last   = (cnt == CntW'(wfpa_pkg::MaxParts - 1));
    stat.at_tail   = (cur_idx == tail);
    stat.out_busy  = rsp_valid && !rsp_ready;
  end

  // Table read address
  always_comb begin
    case (cmd.act)
      wfpa_pkg::ACT_START, wfpa_pkg::ACT_CO_START, wfpa_pkg::ACT_ST_START: rd_addr = head;
      wfpa_pkg::ACT_AS_EVAL, wfpa_pkg::ACT_ST_EVAL: rd_addr = rd_data.link;
      wfpa_pkg::ACT_FR_RD:     rd_addr = cnt[IdxW-1:0];
      wfpa_pkg::ACT_CO_RDNEXT: rd_addr = cur_e.link;
      default:                 rd_addr = cur_idx;
    endcase
  end

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chosen_idx;
    wr_data = rd_data;
    case (cmd.act)
      wfpa_pkg::ACT_WR_TAIL: begin
        wr_en        = 1'b1;
        wr_addr      = old_tail;
        wr_data      = tail_e;
        wr_data.link = chosen_idx;
      end
      wfpa_pkg::ACT_WR_REM: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        wr_data = '{free: 1'b1, owner: '0, len: chosen_len - size_w,
                    start: ch_start + size_w, link: ch_link};
      end
      wfpa_pkg::ACT_WR_CH: begin
        wr_en   = 1'b1;
        wr_addr = chosen_idx;
        wr_data = '{free: 1'b0, owner: tag, len: split ? size_w : chosen_len,
                    start: ch_start, link: split ? slot_r : ch_link};
      end
      wfpa_pkg::ACT_FR_EVAL: begin
        wr_en        = valid[cnt[IdxW-1:0]] && !rd_data.free && (rd_data.owner == tag);
        wr_addr      = cnt[IdxW-1:0];
        wr_data      = rd_data;
        wr_data.free = 1'b1;
      end
      wfpa_pkg::ACT_CO_EVAL: begin
        wr_en   = cur_e.free && rd_data.free;
        wr_addr = cur_idx;
        wr_data = merged;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Control state: valid bits, list pointers, counters, page size
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used       <= '0;
      head       <= '0;
      tail       <= '0;
      page_count <= '0;
      page_bytes <= wfpa_pkg::PageReset;
    end else begin
      if (cfg_we) page_bytes <= cfg_data;
      case (cmd.act)
        wfpa_pkg::ACT_CHECK: begin
          if (!full) page_count <= page_count + AddrW'(new_pages);
        end
        wfpa_pkg::ACT_GRAB_C: begin
          valid[first_free] <= 1'b1;
          used              <= used + CntW'(1);
          if (was_empty) head <= first_free;
          tail <= first_free;
        end
        wfpa_pkg::ACT_GRAB_R: begin
          valid[first_free] <= 1'b1;
          used              <= used + CntW'(1);
        end
        wfpa_pkg::ACT_WR_REM: begin
          if (tail == chosen_idx) tail <= slot_r;
        end
        wfpa_pkg::ACT_CO_EVAL: begin
          if (cur_e.free && rd_data.free) begin
            valid[cur_e.link] <= 1'b0;
            used              <= used - CntW'(1);
            if (cur_e.link == tail) tail <= cur_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      wfpa_pkg::ACT_START: begin
        tag        <= req_tag;
        size       <= req_size;
        cnt        <= '0;
        cur_idx    <= head;
        best_found <= 1'b0;
        dropped    <= 1'b0;
        alloc_addr <= '0;
        old_tail   <= tail;
        was_empty  <= (used == '0);
      end
      wfpa_pkg::ACT_AS_EVAL: begin
        if (rd_data.free && (!best_found || rd_data.len > best_e.len)) begin
          best_found <= 1'b1;
          best_idx   <= cur_idx;
          best_e     <= rd_data;
        end
        if (cur_idx == tail) tail_e <= rd_data;
        cur_idx <= rd_data.link;
        cnt     <= cnt + CntW'(1);
      end
      wfpa_pkg::ACT_AL_DECIDE: begin
        new_pages <= '0;
        rem       <= '0;
        dcnt      <= wfpa_pkg::DivCntW'(SizeW);
        make_new  <= 1'b0;
        grow      <= 1'b0;
        if (used == '0) begin
          make_new <= 1'b1;
          quo      <= size;
          ch_start <= '0;
        end else if (use_best) begin
          chosen_len <= best_e.len;
          chosen_idx <= best_idx;
          ch_start   <= best_e.start;
          ch_link    <= best_e.link;
        end else if (!tail_e.free) begin
          make_new <= 1'b1;
          quo      <= size;
          ch_start <= tail_e.start + tail_e.len;
        end else begin
          grow       <= 1'b1;
          quo        <= size - tail_e.len[SizeW-1:0];
          chosen_idx <= old_tail;
          ch_start   <= tail_e.start;
          ch_link    <= tail_e.link;
        end
      end
      // One restoring division step per cycle
      wfpa_pkg::ACT_DIV_STEP: begin
        if (r_sh >= {1'b0, unit}) begin
          rem <= PageW'(r_sh - {1'b0, unit});
          quo <= {quo[SizeW-2:0], 1'b1};
        end else begin
          rem <= r_sh[PageW-1:0];
          quo <= {quo[SizeW-2:0], 1'b0};
        end
        dcnt <= dcnt - wfpa_pkg::DivCntW'(1);
      end
      wfpa_pkg::ACT_PAGES: new_pages <= quo + SizeW'(rem != '0);
      wfpa_pkg::ACT_MUL:   prod <= mul_full[AddrW-1:0];
      wfpa_pkg::ACT_LEN: begin
        chosen_len <= grow ? (tail_e.len + prod) : prod;
      end
      wfpa_pkg::ACT_CHECK: begin
        if (full) dropped <= 1'b1;
      end
      wfpa_pkg::ACT_GRAB_C: begin
        chosen_idx <= first_free;
        ch_link    <= '0;
      end
      wfpa_pkg::ACT_GRAB_R: slot_r <= first_free;
      wfpa_pkg::ACT_WR_CH:  alloc_addr <= ch_start;
      wfpa_pkg::ACT_FR_EVAL: cnt <= cnt + CntW'(1);
      wfpa_pkg::ACT_CO_START: cur_idx <= head;
      wfpa_pkg::ACT_CO_LOAD:  cur_e <= rd_data;
      wfpa_pkg::ACT_CO_EVAL: begin
        if (cur_e.free && rd_data.free) begin
          cur_e <= merged;
        end else begin
          cur_idx <= cur_e.link;
          cur_e   <= rd_data;
        end
      end
      wfpa_pkg::ACT_ST_START: begin
        cnt   <= '0;
        bsize <= '0;
        baddr <= '0;
      end
      wfpa_pkg::ACT_ST_EVAL: begin
        if (rd_data.free && rd_data.len > bsize) begin
          bsize <= rd_data.len;
          baddr <= rd_data.start;
        end
        cnt <= cnt + CntW'(1);
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status            <= dropped ? wfpa_pkg::STAT_DROPPED : wfpa_pkg::STAT_DONE;
      rsp_alloc_addr        <= alloc_addr;
      rsp_pages_total       <= page_count;
      rsp_largest_free_size <= bsize;
      rsp_largest_free_addr <= baddr;
    end
  end

endmodule

[hw/rtl/worst_fit_partition_allocator.sv]
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Worst-fit partition allocator with page-granular growth. One request is
// handled at a time. An allocate walks the list once for the worst fit, runs
// a 32-step page divider when memory must grow, makes its table writes and
// walks the list again for the statistics; a free reads all 64 slots and
// releases those that hold the tag, merges adjacent free partitions step by
// step and walks the list for the statistics. Every table access goes
// through the table memory, which has one read and one write port. The
// result register lets the next request in while a result waits to be
// taken. Configuration writes are taken at once.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator (
  input logic       clk,
  input logic       rst,
  wfpa_req_if.sink  req,
  wfpa_rsp_if.source rsp,
  wfpa_cfg_if.sink  cfg
);

  wfpa_pkg::cmd_t  cmd;
  wfpa_pkg::stat_t stat;

  // Page size register always takes writes
  assign cfg.ready = 1'b1;

  wfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wfpa_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .req_op                (req.op),
    .req_tag               (req.tag),
    .req_size              (req.size),
    .cfg_we                (cfg.valid),
    .cfg_data              (cfg.data),
    .rsp_ready             (rsp.ready),
    .rsp_valid             (rsp.valid),
    .rsp_status            (rsp.status),
    .rsp_alloc_addr        (rsp.alloc_addr),
    .rsp_pages_total       (rsp.pages_total),
    .rsp_largest_free_size (rsp.largest_free_size),
    .rsp_largest_free_addr (rsp.largest_free_addr)
  );

endmodule

[hw/rtl/wfpa_checker.sv]
// ----------------------------------------------------------------------------
// wfpa_checker
// Port-level checks on the allocator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module wfpa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_status,
  input logic [wfpa_pkg::AddrW-1:0] rsp_alloc_addr,
  input logic [wfpa_pkg::AddrW-1:0] rsp_largest_free_size,
  input logic [wfpa_pkg::AddrW-1:0] rsp_largest_free_addr
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alloc_addr))
    else $error("result changed while stalled");

  // Dropped request places nothing
  a_drop_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == wfpa_pkg::STAT_DROPPED) |-> rsp_alloc_addr == '0)
    else $error("dropped request reports an address");

  // No free partition means no address
  a_free_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_largest_free_size == '0) |-> rsp_largest_free_addr == '0)
    else $error("largest free address without a free partition");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result shown right after reset");

endmodule

bind worst_fit_partition_allocator wfpa_checker u_wfpa_checker (
  .clk                   (clk),
  .rst                   (rst),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_status            (rsp.status),
  .rsp_alloc_addr        (rsp.alloc_addr),
  .rsp_largest_free_size (rsp.largest_free_size),
  .rsp_largest_free_addr (rsp.largest_free_addr)
);

[sim/wfpa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfpa_scoreboard
// Watches the request, result and configuration channels of the worst-fit
// partition allocator, keeps its own copy of the partition table and
// compares every result with the predicted one.
// ----------------------------------------------------------------------------
module wfpa_scoreboard (
  input logic       clk,
  input logic       rst,
  wfpa_req_if       req,
  wfpa_rsp_if       rsp,
  wfpa_cfg_if       cfg,
  output int        fail_count,
  output int        pending,
  output int        results_seen,
  output int        drops_seen
);

  localparam int MaxParts = wfpa_pkg::MaxParts;
  localparam int AddrW    = wfpa_pkg::AddrW;
  localparam int TagW     = wfpa_pkg::TagW;
  localparam int SizeW    = wfpa_pkg::SizeW;
  localparam int PageW    = wfpa_pkg::PageW;

  typedef struct packed {
    logic             status;
    logic [AddrW-1:0] alloc_addr;
    logic [AddrW-1:0] pages_total;
    logic [AddrW-1:0] free_size;
    logic [AddrW-1:0] free_addr;
  } outcome_t;

  // shadow partition table
  logic             slot_used  [MaxParts];
  logic             slot_free  [MaxParts];
  logic [TagW-1:0]  slot_owner [MaxParts];
  logic [AddrW-1:0] slot_len   [MaxParts];
  logic [AddrW-1:0] slot_start [MaxParts];
  int               slot_next  [MaxParts];
  int               head_slot, tail_slot;
  logic [AddrW-1:0] page_tally;
  logic [PageW-1:0] page_setting;
  outcome_t         outcome_q[$];

  function automatic int count_used();
    int n;
    n = 0;
    for (int i = 0; i < MaxParts; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  function automatic int take_slot();
    int i;
    i = 0;
    while (i < MaxParts && slot_used[i]) i++;
    if (i >= MaxParts) i = 0;
    slot_used[i] = 1'b1;
    slot_next[i] = 0;
    return i;
  endfunction

  function automatic logic [63:0] page_unit();
    return (page_setting == 0) ? 64'd1 : {32'd0, page_setting};
  endfunction

  function automatic logic [63:0] pages_needed(logic [63:0] bytes);
    logic [63:0] p;
    p = page_unit();
    return bytes / p + ((bytes % p) != 0 ? 64'd1 : 64'd0);
  endfunction

  // merge adjacent free partitions along the list
  function automatic void merge_free();
    int i, j;
    i = head_slot;
    if (count_used() == 0) return;
    for (int k = 0; k < 2 * MaxParts && i != tail_slot; k++) begin
      j = slot_next[i];
      if (slot_free[i] && slot_free[j]) begin
        slot_len[i] = slot_len[i] + slot_len[j];
        slot_next[i] = slot_next[j];
        if (j == tail_slot) tail_slot = i;
        slot_used[j] = 1'b0;
      end else begin
        i = j;
      end
    end
  endfunction

  function automatic logic [AddrW-1:0] place_block(logic [TagW-1:0] tag,
                                                   logic [63:0] sz, output logic dropped);
    int n, i, best, chosen, r, needed;
    logic have_best, make_new, grow;
    logic [63:0] new_pages, chosen_len;
    logic [AddrW-1:0] new_len, new_start;
    n = count_used(); best = 0; have_best = 0; make_new = 0; grow = 0;
    new_pages = 0; new_len = 0; new_start = 0; dropped = 0;
    i = head_slot;
    for (int k = 0; k < n; k++) begin
      if (slot_free[i] && (!have_best || slot_len[i] > slot_len[best])) begin
        best = i;
        have_best = 1;
      end
      i = slot_next[i];
    end
    if (n == 0 || (!(have_best && slot_len[best] >= sz) && !slot_free[tail_slot])) begin
      make_new = 1;
      new_pages = pages_needed(sz);
      new_len = AddrW'(new_pages * page_unit());
      new_start = (n == 0) ? '0 : slot_start[tail_slot] + slot_len[tail_slot];
      chosen_len = {16'd0, new_len};
    end else if (have_best && slot_len[best] >= sz) begin
      chosen_len = {16'd0, slot_len[best]};
    end else begin
      grow = 1;
      new_pages = pages_needed(sz - slot_len[tail_slot]);
      chosen_len = {16'd0, AddrW'(slot_len[tail_slot] + new_pages * page_unit())};
    end
    needed = (make_new ? 1 : 0) + (chosen_len > sz ? 1 : 0);
    if (n + needed > MaxParts) begin
      dropped = 1;
      return '0;
    end
    page_tally = page_tally + AddrW'(new_pages);
    if (make_new) begin
      chosen = take_slot();
      slot_start[chosen] = new_start;
      slot_len[chosen] = new_len;
      slot_free[chosen] = 1;
      if (n == 0) head_slot = chosen;
      else slot_next[tail_slot] = chosen;
      tail_slot = chosen;
    end else if (grow) begin
      chosen = tail_slot;
      slot_len[chosen] = AddrW'(chosen_len);
    end else begin
      chosen = best;
    end
    if (chosen_len > sz) begin
      r = take_slot();
      slot_len[chosen] = AddrW'(sz);
      slot_start[r] = slot_start[chosen] + AddrW'(sz);
      slot_len[r] = AddrW'(chosen_len - sz);
      slot_free[r] = 1;
      slot_owner[r] = '0;
      slot_next[r] = slot_next[chosen];
      slot_next[chosen] = r;
      if (tail_slot == chosen) tail_slot = r;
    end
    slot_free[chosen] = 0;
    slot_owner[chosen] = tag;
    return slot_start[chosen];
  endfunction

  function automatic outcome_t apply_request(logic op, logic [TagW-1:0] tag,
                                             logic [SizeW-1:0] sz);
    outcome_t o;
    logic dropped;
    int n, i;
    o = '0;
    dropped = 0;
    if (op == wfpa_pkg::OP_ALLOC) begin
      o.alloc_addr = place_block(tag, {32'd0, sz}, dropped);
    end else begin
      for (int s = 0; s < MaxParts; s++)
        if (slot_used[s] && !slot_free[s] && slot_owner[s] == tag) slot_free[s] = 1;
      merge_free();
    end
    n = count_used();
    i = head_slot;
    for (int k = 0; k < n; k++) begin
      if (slot_free[i] && slot_len[i] > o.free_size) begin
        o.free_size = slot_len[i];
        o.free_addr = slot_start[i];
      end
      i = slot_next[i];
    end
    o.status = dropped ? wfpa_pkg::STAT_DROPPED : wfpa_pkg::STAT_DONE;
    if (dropped) o.alloc_addr = '0;
    o.pages_total = page_tally;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  // track requests, configuration and results
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < MaxParts; i++) begin
        slot_used[i] = 0; slot_free[i] = 0; slot_owner[i] = '0;
        slot_len[i] = '0; slot_start[i] = '0; slot_next[i] = 0;
      end
      head_slot = 0; tail_slot = 0; page_tally = '0; page_setting = wfpa_pkg::PageReset;
      outcome_q.delete();
      fail_count = 0;
      results_seen = 0;
      drops_seen = 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) page_setting = cfg.data;
      if (req.valid && req.ready)
        outcome_q.insert(outcome_q.size(), apply_request(req.op, req.tag, req.size));
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", '0, '0);
        end else begin
          want = outcome_q.pop_front();
          if (want.status) drops_seen++;
          if (rsp.status !== want.status)
            report_mismatch("status", AddrW'(rsp.status), AddrW'(want.status));
          if (rsp.alloc_addr !== want.alloc_addr)
            report_mismatch("alloc_addr", rsp.alloc_addr, want.alloc_addr);
          if (rsp.pages_total !== want.pages_total)
            report_mismatch("pages_total", rsp.pages_total, want.pages_total);
          if (rsp.largest_free_size !== want.free_size)
            report_mismatch("largest_free_size", rsp.largest_free_size, want.free_size);
          if (rsp.largest_free_addr !== want.free_addr)
            report_mismatch("largest_free_addr", rsp.largest_free_addr, want.free_addr);
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

[sim/tb_worst_fit_partition_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_worst_fit_partition_allocator
// Drives allocate and free requests with random gaps and result stalls over
// several page sizes; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_worst_fit_partition_allocator;

  localparam int CycleLimit = 3000000;
  localparam int TagW       = wfpa_pkg::TagW;
  localparam int SizeW      = wfpa_pkg::SizeW;
  localparam int PageW      = wfpa_pkg::PageW;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, results_seen, drops_seen;
  int   cycle_count = 0;
  int   sent = 0;

  wfpa_req_if req ();
  wfpa_rsp_if rsp ();
  wfpa_cfg_if cfg ();

  worst_fit_partition_allocator dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  wfpa_scoreboard u_scoreboard (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                                .fail_count(fail_count), .pending(pending),
                                .results_seen(results_seen), .drops_seen(drops_seen));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_worst_fit_partition_allocator: errors");
      $finish;
    end
  end

  // stall results at random, with stall-free stretches
  initial begin
    int gap;
    rsp.ready = 0;
    @(posedge clk);
    forever begin
      gap = ((cycle_count / 5000) % 3 == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        rsp.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      while (!(rsp.valid && rsp.ready)) @(posedge clk);
    end
  end

  // hold valid across back-to-back requests, drop it only for a gap
  task automatic send_request(logic op, logic [TagW-1:0] tag, logic [SizeW-1:0] sz,
                              bit quiet = 0);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.op <= op;
    req.tag <= tag;
    req.size <= sz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  // wait out every outstanding result, then let the block settle
  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_page_size(logic [PageW-1:0] value);
    drain();
    cfg.valid <= 1;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  // mostly small sizes from a few tags so frees hit live partitions
  task automatic random_phase(int count);
    logic [SizeW-1:0] sz;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        sz = $urandom_range(0, 20000);
        if ($urandom_range(0, 19) == 0) sz = $urandom();
        send_request(wfpa_pkg::OP_ALLOC, TagW'($urandom_range(0, 7)), sz);
      end else if (pick < 90) begin
        send_request(wfpa_pkg::OP_FREE, TagW'($urandom_range(0, 7)), $urandom());
      end else begin
        send_request(pick[0] ? wfpa_pkg::OP_FREE : wfpa_pkg::OP_ALLOC, TagW'($urandom()),
                     $urandom());
      end
    end
  endtask

  initial begin
    req.valid = 0; req.op = wfpa_pkg::OP_ALLOC; req.tag = '0; req.size = '0;
    cfg.valid = 0; cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, zero size, extremes, unknown tag, merge
    send_request(wfpa_pkg::OP_FREE, 31'd5, 32'd0);
    send_request(wfpa_pkg::OP_ALLOC, 31'd1, 32'd0);
    send_request(wfpa_pkg::OP_ALLOC, 31'd2, 32'd100);
    send_request(wfpa_pkg::OP_ALLOC, 31'd3, 32'd5000);
    send_request(wfpa_pkg::OP_ALLOC, 31'h7fffffff, 32'hffffffff);
    send_request(wfpa_pkg::OP_ALLOC, 31'd4, 32'd1);
    send_request(wfpa_pkg::OP_FREE, 31'd2, 32'hffffffff);
    send_request(wfpa_pkg::OP_FREE, 31'd12345, 32'd0);
    send_request(wfpa_pkg::OP_FREE, 31'd3, 32'd0);
    send_request(wfpa_pkg::OP_ALLOC, 31'd6, 32'd4096);
    send_request(wfpa_pkg::OP_FREE, 31'h7fffffff, 32'd0);
    send_request(wfpa_pkg::OP_ALLOC, 31'd7, 32'd10);
    // fill the table to force drops
    for (int i = 0; i < 70; i++) send_request(wfpa_pkg::OP_ALLOC, 31'd9, 32'd1, 1);
    send_request(wfpa_pkg::OP_FREE, 31'd9, 32'd0);

    // hold off until every result has come
    drain();
    random_phase(150);

    write_page_size(32'd0);
    random_phase(120);
    write_page_size(32'd1);
    random_phase(120);
    write_page_size(32'hffffffff);
    send_request(wfpa_pkg::OP_ALLOC, 31'd1, 32'hffffffff);
    random_phase(100);
    write_page_size(32'd64);
    random_phase(150);

    drain();
    $display("sent %0d requests over page sizes 4096, 0, 1, max and 64", sent);
    $display("%0d results checked, %0d dropped for a full table", results_seen, drops_seen);
    if (fail_count == 0) begin
      $display("tb_worst_fit_partition_allocator: clean");
    end else begin
      $display("tb_worst_fit_partition_allocator: errors");
    end
    $finish;
  end

endmodule
